[rtl/vfc_pkg.sv]
// ----------------------------------------------------------------------------
// vfc_pkg: shared types and constants of the value frequency counter
// Field widths, the count limit, the sequencer states and the control
// group that the top level broadcasts to every table cell.
// ----------------------------------------------------------------------------
package vfc_pkg;

	localparam int VALUE_W = 32;
	localparam int COUNT_W = 16;
	localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

	typedef enum logic [1:0] {
		ST_COLLECT = 2'b01,
		ST_DRAIN   = 2'b10
	} vfc_state_t;

	// Broadcast to every cell in each cycle.
	typedef struct packed {
		logic absorb;   // a sample transaction is accepted this cycle
		logic append;   // no cell matched, so the first free cell takes the sample
		logic shift;    // every cell takes its right neighbor's contents, the last cell its own
	} cell_ctrl_t;

endpackage

[rtl/vfc_stream_if.sv]
// ----------------------------------------------------------------------------
// vfc_stream_if: valid/ready channels of the value frequency counter
// One interface for the sample stream and one for the result stream.
// ----------------------------------------------------------------------------
interface vfc_in_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] sample_value;
	logic               final_item;

	modport source (output valid, output sample_value, output final_item, input ready);
	modport sink   (input valid, input sample_value, input final_item, output ready);
endinterface

interface vfc_out_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] distinct_value;
	logic        [15:0] occurrences;
	logic               run_end;
	logic               table_overflow;

	modport source (output valid, output distinct_value, output occurrences,
		output run_end, output table_overflow, input ready);
	modport sink   (input valid, input distinct_value, input occurrences,
		input run_end, input table_overflow, output ready);
endinterface

[rtl/vfc_cell.sv]
// ----------------------------------------------------------------------------
// vfc_cell: one entry of the distinct value table
// Holds a value and its count, compares against the broadcast sample and
// takes its right neighbor's contents when the table drains.
// ----------------------------------------------------------------------------
module vfc_cell #(
	parameter int IDX    = 0,
	parameter int USED_W = 7
) (
	input  logic                               clk,
	input  vfc_pkg::cell_ctrl_t                ctrl,
	input  logic [USED_W-1:0]                  used_count,
	input  logic signed [vfc_pkg::VALUE_W-1:0] sample,
	input  logic signed [vfc_pkg::VALUE_W-1:0] next_value,
	input  logic [vfc_pkg::COUNT_W-1:0]        next_count,
	output logic signed [vfc_pkg::VALUE_W-1:0] value,
	output logic [vfc_pkg::COUNT_W-1:0]        count,
	output logic                               hit
);
	import vfc_pkg::*;

	logic signed [VALUE_W-1:0] value_q;
	logic [COUNT_W-1:0]        count_q;
	logic                      occupied;
	logic                      is_free;

	assign occupied = USED_W'(IDX) < used_count;
	assign is_free  = USED_W'(IDX) == used_count;
	assign hit      = occupied && (value_q == sample);

	always_ff @(posedge clk) begin
		if (ctrl.shift) begin
			value_q <= next_value;
			count_q <= next_count;
		end else if (ctrl.absorb) begin
			if (hit) begin
				if (count_q != COUNT_MAX) count_q <= count_q + COUNT_W'(1);
			end else if (ctrl.append && is_free) begin
				value_q <= sample;
				count_q <= COUNT_W'(1);
			end
		end
	end

	assign value = value_q;
	assign count = count_q;
endmodule

[rtl/value_frequency_counter_unit.sv]
// ----------------------------------------------------------------------------
// value_frequency_counter_unit: per-set frequency count of distinct values
// Counts the distinct signed values of a data set in order of first
// appearance and streams out one result per distinct value.
// ----------------------------------------------------------------------------
// Usage:
// Samples arrive on sample_ch, one value per transaction, with final_item
// marking the last of a set. Every sample is compared against all table
// cells at once, so one sample transaction is taken per cycle while a set
// is being collected. A value that matches raises that cell's count, which
// saturates at 65535; a new value goes into the first free cell, or is
// dropped and flagged when all TABLE_DEPTH cells are in use.
// After the final sample is taken the table drains through the row of
// cells towards cell 0: one result transaction per distinct entry on
// result_ch, the first one valid once the sequencer is draining and the
// output register is loaded, then one per cycle as long as the receiver
// takes them. sample_ch stays not ready until the last entry has left the
// table; the output register holds a stalled result and the drain waits.
// The last result carries run_end, and every result of a set that lost
// values carries table_overflow. Reset empties the table and the output
// register; no clearing pass is needed since only occupied cells are read.
// ----------------------------------------------------------------------------
module value_frequency_counter_unit #(
	parameter int TABLE_DEPTH = 64
) (
	input  logic      clk,
	input  logic      arst_n,
	vfc_in_if.sink    sample_ch,
	vfc_out_if.source result_ch
);
	import vfc_pkg::*;

	localparam int USED_W = $clog2(TABLE_DEPTH + 1);

	vfc_state_t                state_q;
	logic [USED_W-1:0]         used_q;
	logic                      overflow_q;

	logic                      out_valid_q;
	logic signed [VALUE_W-1:0] out_value_q;
	logic [COUNT_W-1:0]        out_count_q;
	logic                      out_end_q;
	logic                      out_ovf_q;

	logic signed [VALUE_W-1:0] cell_value [TABLE_DEPTH];
	logic [COUNT_W-1:0]        cell_count [TABLE_DEPTH];
	logic [TABLE_DEPTH-1:0]    cell_hit;

	cell_ctrl_t ctrl;
	logic       take_sample;
	logic       any_hit;
	logic       table_full;
	logic       drain_step;

	assign sample_ch.ready = (state_q == ST_COLLECT);
	assign take_sample     = sample_ch.valid && sample_ch.ready;
	assign any_hit         = |cell_hit;
	assign table_full      = (used_q == USED_W'(TABLE_DEPTH));

	// The drain moves one entry into the output register whenever it is free
	// or its result is being taken in this cycle.
	assign drain_step = (state_q == ST_DRAIN) && (!out_valid_q || result_ch.ready);

	assign ctrl.absorb = take_sample;
	assign ctrl.append = !any_hit;
	assign ctrl.shift  = drain_step;

	// The row of table cells. Cell k hands its contents to cell k-1 on each
	// drain step; the last cell reloads itself, its contents are no longer
	// occupied by then.
	for (genvar k = 0; k < TABLE_DEPTH; k++) begin : g_cell
		localparam int NXT = (k == TABLE_DEPTH - 1) ? k : k + 1;
		vfc_cell #(
			.IDX    (k),
			.USED_W (USED_W)
		) u_cell (
			.clk        (clk),
			.ctrl       (ctrl),
			.used_count (used_q),
			.sample     (sample_ch.sample_value),
			.next_value (cell_value[NXT]),
			.next_count (cell_count[NXT]),
			.value      (cell_value[k]),
			.count      (cell_count[k]),
			.hit        (cell_hit[k])
		);
	end

	// Fill count, sticky drop flag and the collect/drain sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_COLLECT;
			used_q     <= '0;
			overflow_q <= 1'b0;
		end else begin
			unique case (state_q)
				ST_COLLECT: begin
					if (take_sample) begin
						if (!any_hit) begin
							if (table_full) overflow_q <= 1'b1;
							else            used_q     <= used_q + USED_W'(1);
						end
						if (sample_ch.final_item) state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					if (drain_step) begin
						used_q <= used_q - USED_W'(1);
						if (used_q == USED_W'(1)) begin
							state_q    <= ST_COLLECT;
							overflow_q <= 1'b0;
						end
					end
				end
				default: state_q <= ST_COLLECT;
			endcase
		end
	end

	// Output register: control with reset, payload without.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (drain_step) begin
			out_valid_q <= 1'b1;
		end else if (result_ch.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (drain_step) begin
			out_value_q <= cell_value[0];
			out_count_q <= cell_count[0];
			out_end_q   <= (used_q == USED_W'(1));
			out_ovf_q   <= overflow_q;
		end
	end

	assign result_ch.valid          = out_valid_q;
	assign result_ch.distinct_value = out_value_q;
	assign result_ch.occurrences    = out_count_q;
	assign result_ch.run_end        = out_end_q;
	assign result_ch.table_overflow = out_ovf_q;

	// The fill count never passes the number of cells.
	a_used_bound: assert property (@(posedge clk) disable iff (!arst_n)
		used_q <= USED_W'(TABLE_DEPTH))
		else $error("fill count beyond table depth");

	// While draining there is always an entry left to emit.
	a_drain_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DRAIN) |-> (used_q != '0))
		else $error("drain with empty table");

	// The final sample of a set always starts the drain.
	a_final_drains: assert property (@(posedge clk) disable iff (!arst_n)
		(take_sample && sample_ch.final_item) |=> (state_q == ST_DRAIN))
		else $error("final sample did not start the drain");

endmodule

[test/testbench.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for value_frequency_counter_unit
// Streams data sets of signed samples into the counter with random gaps on
// both channels. A tally class keeps its own table of distinct values and
// counts, and turns each final sample into the list of results that must
// come out. Every result transaction is compared field by field with the
// oldest pending one.
// ----------------------------------------------------------------------------
module testbench;
	import vfc_pkg::*;

	localparam int DEPTH          = 64;
	localparam int CYCLE_LIMIT    = 400000;
	localparam int SETTLE_CYCLES  = 20;
	localparam int LONG_HOLD      = 200;
	localparam int HOLD_AT_RESULT = 30;
	localparam int RANDOM_ITEMS   = 265;

	typedef logic signed [VALUE_W-1:0] sample_t;
	typedef logic [COUNT_W-1:0] count_t;

	localparam sample_t VALUE_MIN = {1'b1, {(VALUE_W-1){1'b0}}};
	localparam sample_t VALUE_MAX = ~VALUE_MIN;
	// Odd step, so that base + k * STRIDE never repeats within a set.
	localparam sample_t STRIDE    = 32'h0100_0193;

	typedef struct packed {
		sample_t distinct_value;
		count_t  occurrences;
		logic    run_end;
		logic    table_overflow;
	} freq_result_t;

	// Tracks the distinct values of the set in progress and the results that
	// the counter still owes.
	class freq_tally;
		int unsigned  capacity;
		sample_t      set_values[$];
		count_t       set_counts[$];
		bit           dropped;
		freq_result_t pending_counts[$];
		int unsigned  errors;

		function new(int unsigned cap);
			capacity = cap;
			dropped = 1'b0;
			errors = 0;
		endfunction

		function void note_sample(sample_t v, logic last);
			bit found;
			freq_result_t res;
			found = 1'b0;
			foreach (set_values[k]) begin
				if (!found && set_values[k] == v) begin
					found = 1'b1;
					if (set_counts[k] != COUNT_MAX)
						set_counts[k]++;
				end
			end
			if (!found) begin
				if (set_values.size() < capacity) begin
					set_values.push_back(v);
					set_counts.push_back(1);
				end else begin
					dropped = 1'b1;
				end
			end
			if (last) begin
				foreach (set_values[k]) begin
					res.distinct_value = set_values[k];
					res.occurrences    = set_counts[k];
					res.run_end        = (k == set_values.size() - 1);
					res.table_overflow = dropped;
					pending_counts.push_back(res);
				end
				set_values.delete();
				set_counts.delete();
				dropped = 1'b0;
			end
		endfunction

		function void flag(string field, longint want, longint got);
			$display("%0t: %s mismatch: expected %0d, actual %0d", $time, field, want, got);
			errors++;
		endfunction

		function void check_result(freq_result_t got);
			freq_result_t want;
			if (pending_counts.size() == 0) begin
				$display("%0t: unexpected result: expected none, actual value %0d count %0d",
					$time, got.distinct_value, got.occurrences);
				errors++;
				return;
			end
			want = pending_counts.pop_front();
			if (got.distinct_value !== want.distinct_value)
				flag("distinct_value", want.distinct_value, got.distinct_value);
			if (got.occurrences !== want.occurrences)
				flag("occurrences", want.occurrences, got.occurrences);
			if (got.run_end !== want.run_end)
				flag("run_end", want.run_end, got.run_end);
			if (got.table_overflow !== want.table_overflow)
				flag("table_overflow", want.table_overflow, got.table_overflow);
		endfunction

		function int unsigned outstanding();
			return pending_counts.size();
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n;

	vfc_in_if  sample_ch();
	vfc_out_if result_ch();

	value_frequency_counter_unit #(
		.TABLE_DEPTH(DEPTH)
	) u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.sample_ch (sample_ch),
		.result_ch (result_ch)
	);

	freq_tally   tally = new(DEPTH);
	// When set, neither side inserts idle cycles, so back-to-back traffic
	// is seen on both channels.
	bit          steady = 1'b0;
	int unsigned results_taken = 0;
	int unsigned cycles = 0;

	always #6 clk = ~clk;

	// Hard stop in case the counter hangs on either channel.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("Simulation FAILED");
			$finish;
		end
	end

	// Offers one sample after a random gap and waits until the counter takes
	// it. Inputs change on the falling edge only, and the transaction is
	// recognized on the rising edge, so there is no race with the block.
	task automatic offer_sample(sample_t v, logic last);
		int unsigned gap;
		gap = steady ? 0 : $urandom_range(0, 3);
		repeat (gap) begin
			@(negedge clk);
			sample_ch.valid = 1'b0;
		end
		@(negedge clk);
		sample_ch.valid        = 1'b1;
		sample_ch.sample_value = v;
		sample_ch.final_item   = last;
		do @(posedge clk); while (sample_ch.ready !== 1'b1);
		tally.note_sample(v, last);
	endtask

	// Sends a whole data set; the last sample carries final_item.
	task automatic offer_set(sample_t items[$]);
		foreach (items[k])
			offer_sample(items[k], k == items.size() - 1);
	endtask

	// Result side: a random number of not-ready cycles before each result,
	// with one long hold-off so that the table backs up and the sample
	// channel stalls while the sender keeps offering samples.
	initial begin
		int unsigned hold;
		freq_result_t got;
		wait (arst_n === 1'b1);
		forever begin
			if (results_taken == HOLD_AT_RESULT)
				hold = LONG_HOLD;
			else
				hold = steady ? 0 : $urandom_range(0, 3);
			repeat (hold) begin
				@(negedge clk);
				result_ch.ready = 1'b0;
			end
			@(negedge clk);
			result_ch.ready = 1'b1;
			do @(posedge clk); while (result_ch.valid !== 1'b1);
			got.distinct_value = result_ch.distinct_value;
			got.occurrences    = result_ch.occurrences;
			got.run_end        = result_ch.run_end;
			got.table_overflow = result_ch.table_overflow;
			tally.check_result(got);
			results_taken++;
		end
	end

	// Stimulus: directed sets for the corner cases, then random sets until
	// the item budget is used.
	initial begin
		sample_t     set_items[$];
		sample_t     pool[5];
		sample_t     base;
		int unsigned sent;
		int unsigned set_no;
		int unsigned len;

		sample_ch.valid        = 1'b0;
		sample_ch.sample_value = '0;
		sample_ch.final_item   = 1'b0;
		result_ch.ready        = 1'b0;
		arst_n                 = 1'b0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// A set of one sample gives exactly one result, marked as the last.
		set_items = {VALUE_MIN};
		offer_set(set_items);
		// Both extremes, zero, minus one and alternating bit patterns, with
		// repeats, and a final sample that is already in the table.
		set_items = {VALUE_MAX, sample_t'(0), sample_t'(-1), VALUE_MAX, VALUE_MIN,
			sample_t'(0), sample_t'(32'h5555_5555), sample_t'(32'hAAAA_AAAA), sample_t'(-1)};
		offer_set(set_items);
		// The final sample is a new value and becomes the last entry.
		set_items = {sample_t'(1), sample_t'(2), sample_t'(3)};
		offer_set(set_items);
		// The final sample only raises a count.
		set_items = {sample_t'(42), sample_t'(42)};
		offer_set(set_items);

		sent = 0;
		set_no = 0;
		while (sent < RANDOM_ITEMS) begin
			set_items.delete();
			steady = (set_no % 4 == 3);
			if (set_no == 5) begin
				// Let the counter run dry before the next set starts.
				@(negedge clk);
				sample_ch.valid = 1'b0;
				while (tally.outstanding() != 0)
					@(posedge clk);
			end
			if (set_no == 3) begin
				// Exactly a full table, plus repeats: no overflow.
				base = $urandom;
				for (int k = 0; k < DEPTH; k++)
					set_items.push_back(base + sample_t'(k) * STRIDE);
				repeat (4)
					set_items.push_back(set_items[$urandom_range(0, DEPTH - 1)]);
			end else if (set_no == 8) begin
				// More distinct values than cells. Dropped values show up
				// again, and values in the table keep counting afterwards.
				base = $urandom;
				for (int k = 0; k < DEPTH + 4; k++)
					set_items.push_back(base + sample_t'(k) * STRIDE);
				set_items.push_back(set_items[0]);
				set_items.push_back(set_items[DEPTH + 1]);
				set_items.push_back(set_items[DEPTH - 1]);
			end else if ($urandom_range(0, 3) == 0) begin
				len = $urandom_range(1, 8);
				repeat (len)
					set_items.push_back($urandom);
			end else begin
				// Few values drawn many times, so counts grow.
				foreach (pool[k])
					pool[k] = $urandom;
				len = $urandom_range(1, 12);
				repeat (len)
					set_items.push_back(pool[$urandom_range(0, 4)]);
			end
			offer_set(set_items);
			sent += set_items.size();
			set_no++;
		end

		@(negedge clk);
		sample_ch.valid = 1'b0;
		steady = 1'b0;
		while (tally.outstanding() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (tally.errors == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

endmodule
